// File: src/block_cyclic_index_translator_defines.svh
// assertion macros for the block cyclic index translator
`ifndef BLOCK_CYCLIC_INDEX_TRANSLATOR_DEFINES_SVH
`define BLOCK_CYCLIC_INDEX_TRANSLATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define CIT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define CIT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CIT_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);
`else
`define CIT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define CIT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define CIT_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg)
`endif

`endif

// File: src/cit_pkg.sv
// shared types and constants of the block cyclic index translator
`default_nettype none

package cit_pkg;

    localparam int INDEX_BITS = 16;
    localparam int GRID_BITS  = 10;
    localparam int GREG_W     = GRID_BITS + 1;
    localparam int RANK_W     = 2 * GRID_BITS;
    localparam int CFG_W      = (INDEX_BITS > GREG_W) ? INDEX_BITS : GREG_W;
    localparam int CFG_ADDR_W = 3;
    localparam int FUNC_W     = 3;

    // first divider: element index, rank or padded matrix size over block size or grid size
    localparam int DIVA_NUM_W = (INDEX_BITS + 1 > RANK_W) ? INDEX_BITS + 1 : RANK_W;
    localparam int DIVA_DEN_W = CFG_W;
    // second divider: block number or shifted coordinate over grid size
    localparam int DIVB_NUM_W = (INDEX_BITS > GREG_W) ? INDEX_BITS : GREG_W;
    localparam int DIVB_DEN_W = GREG_W;

    localparam logic [GREG_W-1:0] GRID_MAX = GREG_W'(1) << GRID_BITS;

    localparam logic [FUNC_W-1:0] FUNC_TO_LOCAL     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_TO_GLOBAL    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RANK_TO_GRID = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_GRID_TO_RANK = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_BLOCK_COUNT  = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_ROWS   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_COLS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_ROWS    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_COLS    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MATRIX_ROWS  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_MATRIX_COLS  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_RANK_ORDER   = 3'd6;

    typedef struct packed {
        logic [INDEX_BITS-1:0] block_rows;
        logic [INDEX_BITS-1:0] block_cols;
        logic [GREG_W-1:0]     grid_rows;
        logic [GREG_W-1:0]     grid_cols;
        logic [INDEX_BITS-1:0] matrix_rows;
        logic [INDEX_BITS-1:0] matrix_cols;
        logic                  rank_order;
    } cit_cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [INDEX_BITS-1:0] index_row;
        logic [INDEX_BITS-1:0] index_col;
        logic [GRID_BITS-1:0]  proc_row;
        logic [GRID_BITS-1:0]  proc_col;
        logic [RANK_W-1:0]     rank_in;
        logic [GRID_BITS-1:0]  src_row;
        logic [GRID_BITS-1:0]  src_col;
    } cit_in_t;

    typedef struct packed {
        logic                  status;
        logic [INDEX_BITS-1:0] out_row;
        logic [INDEX_BITS-1:0] out_col;
        logic [GRID_BITS-1:0]  owner_row;
        logic [GRID_BITS-1:0]  owner_col;
        logic [RANK_W-1:0]     rank_out;
    } cit_out_t;

    // context riding along the first divider
    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [GRID_BITS-1:0] proc_row;
        logic [GRID_BITS-1:0] proc_col;
        logic [GRID_BITS-1:0] src_row;
        logic [GRID_BITS-1:0] src_col;
        logic                 coord_err;
    } cit_tag_a_t;

    // context riding along the second divider
    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [GRID_BITS-1:0]  proc_row;
        logic [GRID_BITS-1:0]  proc_col;
        logic                  err;
        logic [INDEX_BITS-1:0] quo_a_row;
        logic [INDEX_BITS-1:0] quo_a_col;
        logic [INDEX_BITS-1:0] rem_a_row;
        logic [INDEX_BITS-1:0] rem_a_col;
    } cit_tag_b_t;

endpackage

`default_nettype wire

// File: src/cit_div2.sv
// two-lane pipelined restoring divider, one quotient bit per stage
`default_nettype none

module cit_div2 #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 16,
    parameter int TAG_W = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] in_num_a,
    input  wire logic [DEN_W-1:0] in_den_a,
    input  wire logic [NUM_W-1:0] in_num_b,
    input  wire logic [DEN_W-1:0] in_den_b,
    input  wire logic [TAG_W-1:0] in_tag,
    output logic                  out_valid,
    output logic      [NUM_W-1:0] out_quo_a,
    output logic      [DEN_W-1:0] out_rem_a,
    output logic      [NUM_W-1:0] out_quo_b,
    output logic      [DEN_W-1:0] out_rem_b,
    output logic      [TAG_W-1:0] out_tag
);

    logic             vld_reg   [NUM_W];
    logic [DEN_W-1:0] rem_a_reg [NUM_W];
    logic [DEN_W-1:0] rem_b_reg [NUM_W];
    logic [NUM_W-1:0] num_a_reg [NUM_W];
    logic [NUM_W-1:0] num_b_reg [NUM_W];
    logic [DEN_W-1:0] den_a_reg [NUM_W];
    logic [DEN_W-1:0] den_b_reg [NUM_W];
    logic [TAG_W-1:0] tag_reg   [NUM_W];

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic             vld_in;
        logic [DEN_W-1:0] rem_a_in, rem_b_in, den_a_in, den_b_in;
        logic [NUM_W-1:0] num_a_in, num_b_in;
        logic [TAG_W-1:0] tag_in;
        logic [DEN_W:0]   trial_a, trial_b;
        logic             fit_a, fit_b;

        if (s == 0)
        begin : g_first
            assign vld_in   = in_valid;
            assign rem_a_in = '0;
            assign rem_b_in = '0;
            assign num_a_in = in_num_a;
            assign num_b_in = in_num_b;
            assign den_a_in = in_den_a;
            assign den_b_in = in_den_b;
            assign tag_in   = in_tag;
        end
        else
        begin : g_next
            assign vld_in   = vld_reg[s-1];
            assign rem_a_in = rem_a_reg[s-1];
            assign rem_b_in = rem_b_reg[s-1];
            assign num_a_in = num_a_reg[s-1];
            assign num_b_in = num_b_reg[s-1];
            assign den_a_in = den_a_reg[s-1];
            assign den_b_in = den_b_reg[s-1];
            assign tag_in   = tag_reg[s-1];
        end

        // shift in the next numerator bit and try one subtraction
        assign trial_a = {rem_a_in, num_a_in[NUM_W-1]};
        assign trial_b = {rem_b_in, num_b_in[NUM_W-1]};
        assign fit_a   = trial_a >= {1'b0, den_a_in};
        assign fit_b   = trial_b >= {1'b0, den_b_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_a_reg[s] <= fit_a ? DEN_W'(trial_a - {1'b0, den_a_in}) : trial_a[DEN_W-1:0];
            rem_b_reg[s] <= fit_b ? DEN_W'(trial_b - {1'b0, den_b_in}) : trial_b[DEN_W-1:0];
            num_a_reg[s] <= {num_a_in[NUM_W-2:0], fit_a};
            num_b_reg[s] <= {num_b_in[NUM_W-2:0], fit_b};
            den_a_reg[s] <= den_a_in;
            den_b_reg[s] <= den_b_in;
            tag_reg[s]   <= tag_in;
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_quo_a = num_a_reg[NUM_W-1];
    assign out_rem_a = rem_a_reg[NUM_W-1];
    assign out_quo_b = num_b_reg[NUM_W-1];
    assign out_rem_b = rem_b_reg[NUM_W-1];
    assign out_tag   = tag_reg[NUM_W-1];

endmodule

`default_nettype wire

// File: src/cit_post.sv
// four-stage finish: products, bound checks and result select
`default_nettype none

module cit_post (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    input  wire cit_pkg::cit_tag_b_t                   tag,
    input  wire logic [cit_pkg::DIVB_NUM_W-1:0]        quo_row,
    input  wire logic [cit_pkg::DIVB_NUM_W-1:0]        quo_col,
    input  wire logic [cit_pkg::DIVB_DEN_W-1:0]        rem_row,
    input  wire logic [cit_pkg::DIVB_DEN_W-1:0]        rem_col,
    input  wire cit_pkg::cit_cfg_t                     cfg,
    output logic                                       out_valid,
    output cit_pkg::cit_out_t                          result
);

    localparam int IB   = cit_pkg::INDEX_BITS;
    localparam int GB   = cit_pkg::GRID_BITS;
    localparam int GW   = cit_pkg::GREG_W;
    localparam int RW   = cit_pkg::RANK_W;
    localparam int MW   = cit_pkg::DIVA_DEN_W;
    localparam int PW   = IB + MW;
    localparam int RPW  = GB + GW;
    localparam int QW   = 2 * IB;
    localparam int SW   = 2 * IB + 1;

    typedef struct packed {
        logic [cit_pkg::FUNC_W-1:0] func;
        logic                       err;
        logic [GB-1:0]              pr;
        logic [GB-1:0]              pc;
        logic [IB-1:0]              rem_a_row;
        logic [IB-1:0]              rem_a_col;
        logic [GB-1:0]              owner_row;
        logic [GB-1:0]              owner_col;
        logic [IB-1:0]              cnt_row;
        logic [IB-1:0]              cnt_col;
        logic [IB-1:0]              loc_row;
        logic [IB-1:0]              loc_col;
        logic                       in_row;
        logic                       in_col;
        logic [RW-1:0]              rank;
    } carry_t;

    carry_t c1_next, c2_next, s1_reg, s2_reg, s3_reg;
    logic   v1_reg, v2_reg, v3_reg, out_valid_reg;

    logic [PW-1:0]  mul_row_next, mul_col_next, s1_mul_row_reg, s1_mul_col_reg;
    logic [RPW-1:0] rank_prod_next, s1_rank_prod_reg;
    logic [GB-1:0]  rank_add_next, s1_rank_add_reg;
    logic [PW-1:0]  blk_row, blk_col;
    logic [IB-1:0]  s2_blk_row_reg, s2_blk_col_reg;
    logic [QW-1:0]  s3_prod_row_reg, s3_prod_col_reg;
    logic [SW-1:0]  glob_row, glob_col;
    logic           ok_row, ok_col, cfg_ok, is_l2g;
    logic [IB-1:0]  mul_a_row, mul_a_col;
    logic [MW-1:0]  mul_b_row, mul_b_col;
    cit_pkg::cit_out_t result_next, result_reg;

    // stage 1: multipliers and block counts
    assign is_l2g = (tag.func == cit_pkg::FUNC_TO_GLOBAL);

    always_comb
    begin
        mul_a_row = is_l2g ? tag.quo_a_row : quo_row[IB-1:0];
        mul_a_col = is_l2g ? tag.quo_a_col : quo_col[IB-1:0];
        mul_b_row = is_l2g ? MW'(cfg.grid_rows) : MW'(cfg.block_rows);
        mul_b_col = is_l2g ? MW'(cfg.grid_cols) : MW'(cfg.block_cols);
        mul_row_next = PW'(mul_a_row) * PW'(mul_b_row);
        mul_col_next = PW'(mul_a_col) * PW'(mul_b_col);
        if (cfg.rank_order)
        begin
            rank_prod_next = RPW'(tag.proc_col) * RPW'(cfg.grid_rows);
            rank_add_next  = tag.proc_row;
        end
        else
        begin
            rank_prod_next = RPW'(tag.proc_row) * RPW'(cfg.grid_cols);
            rank_add_next  = tag.proc_col;
        end
        c1_next           = '0;
        c1_next.func      = tag.func;
        c1_next.err       = tag.err;
        c1_next.pr        = tag.proc_row;
        c1_next.pc        = tag.proc_col;
        c1_next.rem_a_row = tag.rem_a_row;
        c1_next.rem_a_col = tag.rem_a_col;
        c1_next.owner_row = rem_row[GB-1:0];
        c1_next.owner_col = rem_col[GB-1:0];
        c1_next.cnt_row   = IB'(quo_row) + IB'(GW'(tag.proc_row) < rem_row);
        c1_next.cnt_col   = IB'(quo_col) + IB'(GW'(tag.proc_col) < rem_col);
    end

    // stage 2: local index sums, global block numbers, rank sum
    always_comb
    begin
        blk_row         = s1_mul_row_reg + PW'(s1_reg.pr);
        blk_col         = s1_mul_col_reg + PW'(s1_reg.pc);
        c2_next         = s1_reg;
        c2_next.loc_row = IB'(s1_mul_row_reg + PW'(s1_reg.rem_a_row));
        c2_next.loc_col = IB'(s1_mul_col_reg + PW'(s1_reg.rem_a_col));
        c2_next.in_row  = blk_row < PW'(cfg.matrix_rows);
        c2_next.in_col  = blk_col < PW'(cfg.matrix_cols);
        c2_next.rank    = RW'(s1_rank_prod_reg + RPW'(s1_rank_add_reg));
    end

    // stage 4: global index, bound checks, result select
    assign cfg_ok = (cfg.block_rows != '0) && (cfg.block_cols != '0)
                 && (cfg.matrix_rows != '0) && (cfg.matrix_cols != '0)
                 && (cfg.grid_rows != '0) && (cfg.grid_cols != '0)
                 && (cfg.grid_rows <= cit_pkg::GRID_MAX)
                 && (cfg.grid_cols <= cit_pkg::GRID_MAX);
    assign glob_row = SW'(s3_prod_row_reg) + SW'(s3_reg.rem_a_row);
    assign glob_col = SW'(s3_prod_col_reg) + SW'(s3_reg.rem_a_col);
    assign ok_row   = s3_reg.in_row && (glob_row < SW'(cfg.matrix_rows));
    assign ok_col   = s3_reg.in_col && (glob_col < SW'(cfg.matrix_cols));

    always_comb
    begin
        result_next = '0;
        if (!cfg_ok)
        begin
            result_next.status = 1'b1;
        end
        else
        begin
            unique case (s3_reg.func)
                cit_pkg::FUNC_TO_LOCAL:
                begin
                    result_next.out_row   = s3_reg.loc_row;
                    result_next.out_col   = s3_reg.loc_col;
                    result_next.owner_row = s3_reg.owner_row;
                    result_next.owner_col = s3_reg.owner_col;
                end
                cit_pkg::FUNC_TO_GLOBAL:
                begin
                    if (ok_row && ok_col)
                    begin
                        result_next.out_row = glob_row[IB-1:0];
                        result_next.out_col = glob_col[IB-1:0];
                    end
                    else
                    begin
                        result_next.status = 1'b1;
                    end
                end
                cit_pkg::FUNC_RANK_TO_GRID:
                begin
                    if (s3_reg.err)
                    begin
                        result_next.status = 1'b1;
                    end
                    else
                    begin
                        result_next.owner_row = s3_reg.owner_row;
                        result_next.owner_col = s3_reg.owner_col;
                    end
                end
                cit_pkg::FUNC_GRID_TO_RANK:
                begin
                    if (s3_reg.err)
                    begin
                        result_next.status = 1'b1;
                    end
                    else
                    begin
                        result_next.rank_out = s3_reg.rank;
                    end
                end
                cit_pkg::FUNC_BLOCK_COUNT:
                begin
                    result_next.out_row = s3_reg.cnt_row;
                    result_next.out_col = s3_reg.cnt_col;
                end
                default:
                begin
                    result_next.status = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg           <= c1_next;
        s1_mul_row_reg   <= mul_row_next;
        s1_mul_col_reg   <= mul_col_next;
        s1_rank_prod_reg <= rank_prod_next;
        s1_rank_add_reg  <= rank_add_next;
        s2_reg           <= c2_next;
        s2_blk_row_reg   <= blk_row[IB-1:0];
        s2_blk_col_reg   <= blk_col[IB-1:0];
        // stage 3: global element offset of the block
        s3_reg           <= s2_reg;
        s3_prod_row_reg  <= QW'(s2_blk_row_reg) * QW'(cfg.block_rows);
        s3_prod_col_reg  <= QW'(s2_blk_col_reg) * QW'(cfg.block_cols);
        result_reg       <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

// File: src/block_cyclic_index_translator.sv
// top level of the block cyclic index translator
//
// translates matrix indices for a 2-d block cyclic layout over a process grid
// - item channel: an item transfers on a rising edge with start high and busy
//   low; busy is always low, so one item may transfer every cycle
// - result channel: done is high for exactly one cycle with the result on
//   result; the receiver cannot stall, so nothing in the pipe ever waits
// - config port: cfg_we, cfg_addr, cfg_wdata write one register per edge;
//   write only while no item is in flight
// - path: from transfer to done an item passes the first divider pipe, the
//   second divider pipe and then the finishing stages of cit_post
// - throughput: one item per cycle, every stage advances each cycle
// - reset: size registers go to 1, rank order to row major, all stage valid
//   bits clear; no memories, so no clearing pass
//
`default_nettype none
`include "block_cyclic_index_translator_defines.svh"

module block_cyclic_index_translator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire cit_pkg::cit_in_t                   item,
    output logic                                    done,
    output cit_pkg::cit_out_t                       result,
    input  wire logic                               cfg_we,
    input  wire logic [cit_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [cit_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int IB      = cit_pkg::INDEX_BITS;
    localparam int GB      = cit_pkg::GRID_BITS;
    localparam int GW      = cit_pkg::GREG_W;
    localparam int NA      = cit_pkg::DIVA_NUM_W;
    localparam int DA      = cit_pkg::DIVA_DEN_W;
    localparam int NB      = cit_pkg::DIVB_NUM_W;
    localparam int DB      = cit_pkg::DIVB_DEN_W;
    localparam int TAG_A_W = $bits(cit_pkg::cit_tag_a_t);
    localparam int TAG_B_W = $bits(cit_pkg::cit_tag_b_t);
    localparam int LATENCY = NA + NB + 4;

    cit_pkg::cit_cfg_t cfg_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_rows   <= IB'(1);
            cfg_reg.block_cols   <= IB'(1);
            cfg_reg.grid_rows    <= GW'(1);
            cfg_reg.grid_cols    <= GW'(1);
            cfg_reg.matrix_rows  <= IB'(1);
            cfg_reg.matrix_cols  <= IB'(1);
            cfg_reg.rank_order   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                cit_pkg::CFG_BLOCK_ROWS:   cfg_reg.block_rows   <= cfg_wdata[IB-1:0];
                cit_pkg::CFG_BLOCK_COLS:   cfg_reg.block_cols   <= cfg_wdata[IB-1:0];
                cit_pkg::CFG_GRID_ROWS:    cfg_reg.grid_rows    <= cfg_wdata[GW-1:0];
                cit_pkg::CFG_GRID_COLS:    cfg_reg.grid_cols    <= cfg_wdata[GW-1:0];
                cit_pkg::CFG_MATRIX_ROWS:  cfg_reg.matrix_rows  <= cfg_wdata[IB-1:0];
                cit_pkg::CFG_MATRIX_COLS:  cfg_reg.matrix_cols  <= cfg_wdata[IB-1:0];
                cit_pkg::CFG_RANK_ORDER:   cfg_reg.rank_order   <= cfg_wdata[0];
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // fully pipelined, never holds off a transfer
    assign busy = 1'b0;

    // operands of the first divider
    logic [NA-1:0]        num_a_row, num_a_col;
    logic [DA-1:0]        den_a_row, den_a_col;
    cit_pkg::cit_tag_a_t  tag_a_in;

    always_comb
    begin
        num_a_row = '0;
        num_a_col = '0;
        unique case (item.func)
            cit_pkg::FUNC_TO_LOCAL, cit_pkg::FUNC_TO_GLOBAL:
            begin
                num_a_row = NA'(item.index_row);
                num_a_col = NA'(item.index_col);
            end
            cit_pkg::FUNC_RANK_TO_GRID:
            begin
                num_a_row = NA'(item.rank_in);
            end
            cit_pkg::FUNC_BLOCK_COUNT:
            begin
                // ceiling of matrix size over block size
                num_a_row = NA'(cfg_reg.matrix_rows) + NA'(cfg_reg.block_rows) - NA'(1);
                num_a_col = NA'(cfg_reg.matrix_cols) + NA'(cfg_reg.block_cols) - NA'(1);
            end
            default:
            begin
                num_a_row = '0;
            end
        endcase
        if (item.func == cit_pkg::FUNC_RANK_TO_GRID)
        begin
            den_a_row = cfg_reg.rank_order ? DA'(cfg_reg.grid_rows) : DA'(cfg_reg.grid_cols);
        end
        else
        begin
            den_a_row = DA'(cfg_reg.block_rows);
        end
        den_a_col          = DA'(cfg_reg.block_cols);
        tag_a_in.func      = item.func;
        tag_a_in.proc_row  = item.proc_row;
        tag_a_in.proc_col  = item.proc_col;
        tag_a_in.src_row   = item.src_row;
        tag_a_in.src_col   = item.src_col;
        tag_a_in.coord_err = (GW'(item.proc_row) >= cfg_reg.grid_rows)
                          || (GW'(item.proc_col) >= cfg_reg.grid_cols);
    end

    logic                a_valid;
    logic [NA-1:0]       a_quo_row, a_quo_col;
    logic [DA-1:0]       a_rem_row, a_rem_col;
    logic [TAG_A_W-1:0]  a_tag;

    cit_div2 #(
        .NUM_W (NA),
        .DEN_W (DA),
        .TAG_W (TAG_A_W)
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_num_a  (num_a_row),
        .in_den_a  (den_a_row),
        .in_num_b  (num_a_col),
        .in_den_b  (den_a_col),
        .in_tag    (tag_a_in),
        .out_valid (a_valid),
        .out_quo_a (a_quo_row),
        .out_rem_a (a_rem_row),
        .out_quo_b (a_quo_col),
        .out_rem_b (a_rem_col),
        .out_tag   (a_tag)
    );

    // operands of the second divider: block over grid, or shifted coordinate
    cit_pkg::cit_tag_a_t  tag_a_out;
    cit_pkg::cit_tag_b_t  tag_b_in;
    logic [GB-1:0]        part_row, part_col;
    logic                 rank_err;
    logic [NB-1:0]        num_b_row, num_b_col;
    logic [DB-1:0]        den_b_row, den_b_col;

    always_comb
    begin
        tag_a_out = cit_pkg::cit_tag_a_t'(a_tag);
        if (cfg_reg.rank_order)
        begin
            part_row = a_rem_row[GB-1:0];
            part_col = a_quo_row[GB-1:0];
            rank_err = a_quo_row >= NA'(cfg_reg.grid_cols);
        end
        else
        begin
            part_row = a_quo_row[GB-1:0];
            part_col = a_rem_row[GB-1:0];
            rank_err = a_quo_row >= NA'(cfg_reg.grid_rows);
        end
        if (tag_a_out.func == cit_pkg::FUNC_RANK_TO_GRID)
        begin
            num_b_row    = NB'(GW'(part_row) + GW'(tag_a_out.src_row));
            num_b_col    = NB'(GW'(part_col) + GW'(tag_a_out.src_col));
            tag_b_in.err = rank_err;
        end
        else
        begin
            num_b_row    = a_quo_row[NB-1:0];
            num_b_col    = a_quo_col[NB-1:0];
            tag_b_in.err = tag_a_out.coord_err;
        end
        den_b_row          = DB'(cfg_reg.grid_rows);
        den_b_col          = DB'(cfg_reg.grid_cols);
        tag_b_in.func      = tag_a_out.func;
        tag_b_in.proc_row  = tag_a_out.proc_row;
        tag_b_in.proc_col  = tag_a_out.proc_col;
        tag_b_in.quo_a_row = a_quo_row[IB-1:0];
        tag_b_in.quo_a_col = a_quo_col[IB-1:0];
        tag_b_in.rem_a_row = a_rem_row[IB-1:0];
        tag_b_in.rem_a_col = a_rem_col[IB-1:0];
    end

    logic                b_valid;
    logic [NB-1:0]       b_quo_row, b_quo_col;
    logic [DB-1:0]       b_rem_row, b_rem_col;
    logic [TAG_B_W-1:0]  b_tag;

    cit_div2 #(
        .NUM_W (NB),
        .DEN_W (DB),
        .TAG_W (TAG_B_W)
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid),
        .in_num_a  (num_b_row),
        .in_den_a  (den_b_row),
        .in_num_b  (num_b_col),
        .in_den_b  (den_b_col),
        .in_tag    (tag_b_in),
        .out_valid (b_valid),
        .out_quo_a (b_quo_row),
        .out_rem_a (b_rem_row),
        .out_quo_b (b_quo_col),
        .out_rem_b (b_rem_col),
        .out_tag   (b_tag)
    );

    // products, range checks and the registered result
    cit_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid),
        .tag       (cit_pkg::cit_tag_b_t'(b_tag)),
        .quo_row   (b_quo_row),
        .quo_col   (b_quo_col),
        .rem_row   (b_rem_row),
        .rem_col   (b_rem_col),
        .cfg       (cfg_reg),
        .out_valid (done),
        .result    (result)
    );

    // result qualifiers for the checks below
    logic err_result, ok_result, payload_clear, owner_ok;

    assign err_result    = done && result.status;
    assign ok_result     = done && !result.status;
    assign payload_clear = (result.out_row == '0) && (result.out_col == '0)
                        && (result.owner_row == '0) && (result.owner_col == '0)
                        && (result.rank_out == '0);
    assign owner_ok      = (GW'(result.owner_row) < cfg_reg.grid_rows)
                        && (GW'(result.owner_col) < cfg_reg.grid_cols);

    // every transfer produces its result after the delay given by LATENCY
    `CIT_ASSERT_DELAY(a_fixed_latency, clk, rst_n, start && !busy, LATENCY, done, "late result")
    // an error result carries nothing but the status bit
    `CIT_ASSERT_IMPLIES(a_error_clean, clk, rst_n, err_result, payload_clear, "error fields set")
    // a good result names an owner inside the grid
    `CIT_ASSERT_ALWAYS(a_owner_in_grid, clk, rst_n, !ok_result || owner_ok, "owner outside grid")

endmodule

`default_nettype wire
